[sv/page_bitmap_pixel_expander_assert.svh]
// ----------------------------------------------------------------------------
// pixel expander assertion macros
// immediate-implication and next-cycle checks used by pbpe_emit
// ----------------------------------------------------------------------------
`ifndef PAGE_BITMAP_PIXEL_EXPANDER_ASSERT_SVH
`define PAGE_BITMAP_PIXEL_EXPANDER_ASSERT_SVH

// consequent must hold in the same cycle
`define PBPE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pbpe check failed");

// consequent must hold in the following cycle
`define PBPE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pbpe check failed");

`endif

[sv/pbpe_pkg.sv]
// ----------------------------------------------------------------------------
// pbpe_pkg
// shared widths, codes and types of the page bitmap pixel expander
// ----------------------------------------------------------------------------
package pbpe_pkg;

   localparam int OFF_W   = 19;
   localparam int BYTE_W  = 8;
   localparam int DIM_W   = 12;
   localparam int COORD_W = 12;
   localparam int PIX_W   = 11;
   localparam int UNIT_W  = 10;
   localparam int IDX_W   = 3;
   localparam int NPIX    = 8;
   localparam int SEL_W   = 3;

   localparam logic [BYTE_W-1:0] BYTE_BLANK = 8'hFF;

   localparam logic [IDX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [IDX_W-1:0] REG_PAGE_W = 3'd1;
   localparam logic [IDX_W-1:0] REG_PAGE_H = 3'd2;
   localparam logic [IDX_W-1:0] REG_SCR_W  = 3'd3;
   localparam logic [IDX_W-1:0] REG_SCR_H  = 3'd4;

   localparam logic [DIM_W-1:0] RESET_PAGE_W = 12'd480;
   localparam logic [DIM_W-1:0] RESET_PAGE_H = 12'd800;
   localparam logic [DIM_W-1:0] RESET_SCR_W  = 12'd480;
   localparam logic [DIM_W-1:0] RESET_SCR_H  = 12'd800;

   typedef enum logic [1:0] {
      MODE_MONO      = 2'd0,
      MODE_GRAY_BASE = 2'd1,
      MODE_GRAY_LSB  = 2'd2,
      MODE_GRAY_MSB  = 2'd3
   } mode_type;

   typedef struct packed {
      mode_type         mode;
      logic [DIM_W-1:0] page_w;
      logic [DIM_W-1:0] page_h;
      logic [DIM_W-1:0] scr_w;
      logic [DIM_W-1:0] scr_h;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      mode:   MODE_MONO,
      page_w: RESET_PAGE_W,
      page_h: RESET_PAGE_H,
      scr_w:  RESET_SCR_W,
      scr_h:  RESET_SCR_H
   };

   typedef struct packed {
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] lo;
      logic              err;
   } div_payload_type;

   typedef struct packed {
      logic [NPIX-1:0]    mask;
      logic [COORD_W-1:0] xb;
      logic [COORD_W-1:0] yb;
      logic               step_x;
      logic               ink;
      logic               err;
   } slot_type;

endpackage

[sv/pbpe_req_if.sv]
// ----------------------------------------------------------------------------
// pbpe_req_if
// input item channel: byte offset and the two plane bytes
// ----------------------------------------------------------------------------
interface pbpe_req_if;
   import pbpe_pkg::*;

   logic              valid;
   logic              ready;
   logic [OFF_W-1:0]  byte_offset;
   logic [BYTE_W-1:0] byte_hi;
   logic [BYTE_W-1:0] byte_lo;

   modport source (output valid, byte_offset, byte_hi, byte_lo, input ready);
   modport sink   (input valid, byte_offset, byte_hi, byte_lo, output ready);
endinterface

[sv/pbpe_rsp_if.sv]
// ----------------------------------------------------------------------------
// pbpe_rsp_if
// result item channel: one pixel draw command or an offset error
// ----------------------------------------------------------------------------
interface pbpe_rsp_if;
   import pbpe_pkg::*;

   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_x;
   logic [PIX_W-1:0] pixel_y;
   logic             ink_black;
   logic             overflow_error;
   logic             last_of_byte;

   modport source (output valid, pixel_x, pixel_y, ink_black, overflow_error,
                   last_of_byte, input ready);
   modport sink   (input valid, pixel_x, pixel_y, ink_black, overflow_error,
                   last_of_byte, output ready);
endinterface

[sv/pbpe_csr_if.sv]
// ----------------------------------------------------------------------------
// pbpe_csr_if
// configuration write channel: register index and write data
// ----------------------------------------------------------------------------
interface pbpe_csr_if;
   import pbpe_pkg::*;

   logic             valid;
   logic             ready;
   logic [IDX_W-1:0] index;
   logic [DIM_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/pbpe_csr.sv]
// ----------------------------------------------------------------------------
// pbpe_csr
// configuration registers: mode, page size and screen clip size
// ----------------------------------------------------------------------------
module pbpe_csr (
   input  logic             clock,
   input  logic             reset,
   pbpe_csr_if.sink         csr,
   output pbpe_pkg::cfg_type cfg
);
   import pbpe_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            REG_MODE:   cfg_in.mode   = mode_type'(csr.data[1:0]);
            REG_PAGE_W: cfg_in.page_w = csr.data;
            REG_PAGE_H: cfg_in.page_h = csr.data;
            REG_SCR_W:  cfg_in.scr_w  = csr.data;
            REG_SCR_H:  cfg_in.scr_h  = csr.data;
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

[sv/pbpe_div_stage.sv]
// ----------------------------------------------------------------------------
// pbpe_div_stage
// one restoring division step: offset by bytes per row or column
// ----------------------------------------------------------------------------
module pbpe_div_stage #(
   parameter int DIV_W = 29,
   parameter int QW    = 11,
   parameter int SHIFT = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [DIV_W-1:0]              in_rem,
   input  logic [QW-1:0]                 in_q,
   input  logic [pbpe_pkg::UNIT_W-1:0]   in_unit,
   input  pbpe_pkg::div_payload_type     in_pay,
   output logic                          out_valid,
   output logic [DIV_W-1:0]              out_rem,
   output logic [QW-1:0]                 out_q,
   output logic [pbpe_pkg::UNIT_W-1:0]   out_unit,
   output pbpe_pkg::div_payload_type     out_pay
);
   import pbpe_pkg::*;

   logic [DIV_W-1:0] trial;
   logic             ge;
   logic [DIV_W-1:0] rem_in;
   logic [QW-1:0]    q_in;

   logic                 valid_ff;
   logic [DIV_W-1:0]     rem_ff;
   logic [QW-1:0]        q_ff;
   logic [UNIT_W-1:0]    unit_ff;
   div_payload_type      pay_ff;

   always_comb begin
      trial  = DIV_W'(in_unit) << SHIFT;
      ge     = in_rem >= trial;
      rem_in = ge ? in_rem - trial : in_rem;
      q_in   = {in_q[QW-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff  <= rem_in;
         q_ff    <= q_in;
         unit_ff <= in_unit;
         pay_ff  <= in_pay;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_q     = q_ff;
   assign out_unit  = unit_ff;
   assign out_pay   = pay_ff;
endmodule

[sv/pbpe_decode.sv]
// ----------------------------------------------------------------------------
// pbpe_decode
// turns row or column and byte position into a draw mask and base coordinate
// ----------------------------------------------------------------------------
module pbpe_decode #(
   parameter int QW = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [QW-1:0]                q,
   input  logic [pbpe_pkg::UNIT_W-1:0]  rem,
   input  pbpe_pkg::div_payload_type    pay,
   input  pbpe_pkg::cfg_type            cfg,
   output logic                         out_valid,
   output pbpe_pkg::slot_type           out_item
);
   import pbpe_pkg::*;

   logic [DIM_W:0] w13, h13, sw13, sh13;
   logic [DIM_W:0] line13, base13, gx13;
   logic [DIM_W:0] pos13;
   logic [1:0]     val;
   logic           draw;
   logic           line_ok;
   slot_type       item_in;
   logic           valid_in;

   logic     valid_ff;
   slot_type item_ff;

   always_comb begin
      w13     = {1'b0, cfg.page_w};
      h13     = {1'b0, cfg.page_h};
      sw13    = {1'b0, cfg.scr_w};
      sh13    = {1'b0, cfg.scr_h};
      line13  = (DIM_W+1)'(q);
      base13  = (DIM_W+1)'({rem, 3'b000});
      gx13    = w13 - (DIM_W+1)'(1) - line13;
      item_in = '0;
      pos13   = '0;
      val     = '0;
      draw    = 1'b0;
      line_ok = 1'b0;
      if (cfg.mode == MODE_MONO) begin
         line_ok        = (line13 < h13) && (line13 < sh13) && (pay.hi != BYTE_BLANK);
         item_in.xb     = base13[COORD_W-1:0];
         item_in.yb     = line13[COORD_W-1:0];
         item_in.step_x = 1'b1;
         item_in.ink    = 1'b1;
         for (int b = 0; b < NPIX; b++) begin
            pos13 = base13 + (DIM_W+1)'(b);
            item_in.mask[b] = line_ok && (pos13 < w13) && (pos13 < sw13)
                              && !pay.hi[NPIX-1-b];
         end
      end else begin
         line_ok        = gx13 < sw13;
         item_in.xb     = gx13[COORD_W-1:0];
         item_in.yb     = base13[COORD_W-1:0];
         item_in.step_x = 1'b0;
         item_in.ink    = (cfg.mode == MODE_GRAY_BASE);
         for (int b = 0; b < NPIX; b++) begin
            pos13 = base13 + (DIM_W+1)'(b);
            val   = {pay.hi[NPIX-1-b], pay.lo[NPIX-1-b]};
            case (cfg.mode)
               MODE_GRAY_BASE: draw = (val != 2'b00);
               MODE_GRAY_LSB:  draw = (val == 2'b01);
               MODE_GRAY_MSB:  draw = (val == 2'b01) || (val == 2'b10);
               default:        draw = 1'b0;
            endcase
            item_in.mask[b] = line_ok && (pos13 < h13) && (pos13 < sh13) && draw;
         end
      end
      if (pay.err) begin
         item_in      = '0;
         item_in.mask = NPIX'(1);
      end
      item_in.err = pay.err;
      valid_in    = in_valid && (item_in.mask != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

[sv/pbpe_emit.sv]
// ----------------------------------------------------------------------------
// pbpe_emit
// holds one decoded byte and sends its pixels one item per cycle unless rsp.ready stalls
// ----------------------------------------------------------------------------
`include "page_bitmap_pixel_expander_assert.svh"

module pbpe_emit (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  pbpe_pkg::slot_type in_item,
   output logic               take,
   pbpe_rsp_if.source         rsp
);
   import pbpe_pkg::*;

   logic               slot_valid_ff;
   slot_type           slot_ff;
   logic               slot_valid_in;
   slot_type           slot_in;

   logic               rsp_valid_ff;
   logic [PIX_W-1:0]   px_ff, py_ff;
   logic               ink_ff, err_ff, last_ff;
   logic               rsp_valid_in;

   logic               out_load;
   logic               fire;
   logic               last;
   logic [SEL_W-1:0]   idx;
   logic [NPIX-1:0]    rest;
   logic [COORD_W-1:0] xo, yo;

   always_comb begin
      idx = '0;
      for (int b = NPIX - 1; b >= 0; b--) begin
         if (slot_ff.mask[b]) begin
            idx = SEL_W'(b);
         end
      end
      rest     = slot_ff.mask & ~(NPIX'(1) << idx);
      last     = (rest == '0);
      out_load = !rsp_valid_ff || rsp.ready;
      fire     = slot_valid_ff && out_load;
      take     = !slot_valid_ff || (fire && last);
      xo = slot_ff.xb + (slot_ff.step_x ? COORD_W'(idx) : '0);
      yo = slot_ff.yb + (slot_ff.step_x ? '0 : COORD_W'(idx));

      slot_valid_in = slot_valid_ff;
      slot_in       = slot_ff;
      if (take) begin
         slot_valid_in = in_valid;
         slot_in       = in_item;
      end else if (fire) begin
         slot_in.mask = rest;
      end

      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (out_load) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (fire) begin
         px_ff   <= xo[PIX_W-1:0];
         py_ff   <= yo[PIX_W-1:0];
         ink_ff  <= slot_ff.ink;
         err_ff  <= slot_ff.err;
         last_ff <= last;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.pixel_x        = px_ff;
   assign rsp.pixel_y        = py_ff;
   assign rsp.ink_black      = ink_ff;
   assign rsp.overflow_error = err_ff;
   assign rsp.last_of_byte   = last_ff;

   `PBPE_ASSERT_IMP(a_slot_nonempty, clock, reset, slot_valid_ff, slot_ff.mask != '0)
   `PBPE_ASSERT_NXT(a_slot_holds, clock, reset, slot_valid_ff && !out_load, slot_valid_ff && $stable(slot_ff.mask))
   `PBPE_ASSERT_IMP(a_err_alone, clock, reset, rsp_valid_ff && err_ff, last_ff && !ink_ff && px_ff == '0 && py_ff == '0)
endmodule

[sv/page_bitmap_pixel_expander.sv]
// ----------------------------------------------------------------------------
// page_bitmap_pixel_expander
// expands page bitmap bytes into clipped pixel draw commands
// ----------------------------------------------------------------------------
//  channel   dir   handshake     carries
//  req_port  in    valid/ready   byte_offset, byte_hi, byte_lo
//  rsp_port  out   valid/ready   pixel_x, pixel_y, ink_black, overflow_error,
//                                last_of_byte
//  csr_port  in    valid/ready   index, data (always ready)
//
//  one result leaves per cycle unless rsp_port.ready stalls; a byte gives up
//  to 8 results, and passes s0, s1, the division stages, the decode register,
//  the serializer slot and the result register from acceptance to its first
//  result. the offset divide is one quotient bit per stage; a byte that draws
//  nothing leaves no result and is dropped at decode, before the serializer.
//  reset is synchronous and clears all valid bits and the configuration.
//  a waiting result with rsp_port.ready low stops the serializer, and a busy
//  serializer holds every earlier stage in place.
// ----------------------------------------------------------------------------
module page_bitmap_pixel_expander #(
   parameter int MAX_DIM = 2048
) (
   input  logic        clock,
   input  logic        reset,
   pbpe_req_if.sink    req_port,
   pbpe_rsp_if.source  rsp_port,
   pbpe_csr_if.sink    csr_port
);
   import pbpe_pkg::*;

   localparam int QW      = $clog2(MAX_DIM);
   localparam int DIV_W   = OFF_W + UNIT_W;
   localparam int PLANE_W = UNIT_W + DIM_W;

   cfg_type cfg;
   logic    en;

   logic [DIM_W-1:0] dim_a, dim_b;
   logic [DIM_W:0]   unit_sum;
   logic             dims_ok_in;

   logic              s0_valid_ff;
   logic [OFF_W-1:0]  s0_off_ff;
   logic [BYTE_W-1:0] s0_hi_ff, s0_lo_ff;
   logic [UNIT_W-1:0] s0_unit_ff;
   logic [DIM_W-1:0]  s0_other_ff;
   logic              s0_ok_ff;

   logic               s1_valid_ff;
   logic [OFF_W-1:0]   s1_off_ff;
   logic [BYTE_W-1:0]  s1_hi_ff, s1_lo_ff;
   logic [UNIT_W-1:0]  s1_unit_ff;
   logic [PLANE_W-1:0] s1_plane_ff;
   logic [PLANE_W-1:0] plane_in;

   logic              valid_c [QW+1];
   logic [DIV_W-1:0]  rem_c   [QW+1];
   logic [QW-1:0]     q_c     [QW+1];
   logic [UNIT_W-1:0] unit_c  [QW+1];
   div_payload_type   pay_c   [QW+1];

   logic     dec_valid;
   slot_type dec_item;

   pbpe_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_port),
      .cfg   (cfg)
   );

   assign req_port.ready = en;

   always_comb begin
      dim_a      = (cfg.mode == MODE_MONO) ? cfg.page_w : cfg.page_h;
      dim_b      = (cfg.mode == MODE_MONO) ? cfg.page_h : cfg.page_w;
      unit_sum   = (DIM_W+1)'(dim_a) + (DIM_W+1)'(7);
      dims_ok_in = (cfg.page_w != '0) && (cfg.page_h != '0)
                   && ({1'b0, cfg.page_w} <= (DIM_W+1)'(MAX_DIM))
                   && ({1'b0, cfg.page_h} <= (DIM_W+1)'(MAX_DIM));
      plane_in   = s0_ok_ff ? PLANE_W'(s0_unit_ff) * PLANE_W'(s0_other_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s0_valid_ff <= req_port.valid;
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_off_ff   <= req_port.byte_offset;
         s0_hi_ff    <= req_port.byte_hi;
         s0_lo_ff    <= req_port.byte_lo;
         s0_unit_ff  <= unit_sum[DIM_W:3];
         s0_other_ff <= dim_b;
         s0_ok_ff    <= dims_ok_in;
         s1_off_ff   <= s0_off_ff;
         s1_hi_ff    <= s0_hi_ff;
         s1_lo_ff    <= s0_lo_ff;
         s1_unit_ff  <= s0_unit_ff;
         s1_plane_ff <= plane_in;
      end
   end

   always_comb begin
      valid_c[0]   = s1_valid_ff;
      rem_c[0]     = DIV_W'(s1_off_ff);
      q_c[0]       = '0;
      unit_c[0]    = s1_unit_ff;
      pay_c[0].hi  = s1_hi_ff;
      pay_c[0].lo  = s1_lo_ff;
      pay_c[0].err = PLANE_W'(s1_off_ff) >= s1_plane_ff;
   end

   for (genvar j = 0; j < QW; j++) begin : g_div
      pbpe_div_stage #(
         .DIV_W (DIV_W),
         .QW    (QW),
         .SHIFT (QW - 1 - j)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_c[j]),
         .in_rem    (rem_c[j]),
         .in_q      (q_c[j]),
         .in_unit   (unit_c[j]),
         .in_pay    (pay_c[j]),
         .out_valid (valid_c[j+1]),
         .out_rem   (rem_c[j+1]),
         .out_q     (q_c[j+1]),
         .out_unit  (unit_c[j+1]),
         .out_pay   (pay_c[j+1])
      );
   end

   pbpe_decode #(
      .QW (QW)
   ) u_decode (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_c[QW]),
      .q         (q_c[QW]),
      .rem       (rem_c[QW][UNIT_W-1:0]),
      .pay       (pay_c[QW]),
      .cfg       (cfg),
      .out_valid (dec_valid),
      .out_item  (dec_item)
   );

   pbpe_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .in_valid (dec_valid),
      .in_item  (dec_item),
      .take     (en),
      .rsp      (rsp_port)
   );
endmodule

[tb/page_bitmap_pixel_expander_tb.sv]
// ----------------------------------------------------------------------------
// page_bitmap_pixel_expander_tb
// drives page bitmap bytes through the expander under several page and screen
// settings in all four modes, predicts every pixel draw and offset error, and
// compares each result field by field while both channels idle at random
// ----------------------------------------------------------------------------
module page_bitmap_pixel_expander_tb;
   import pbpe_pkg::*;

   localparam int MAX_DIM        = 2048;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_PHASES  = 10;
   localparam int PHASE_BYTES    = 45;

   class draw_predictor;
      typedef struct packed {
         logic [PIX_W-1:0] x;
         logic [PIX_W-1:0] y;
         logic             ink;
         logic             err;
         logic             last;
      } draw_cmd_type;

      cfg_type      cfg;
      draw_cmd_type due_draws[$];
      int           mismatches;
      int           bytes_seen;
      int           pixels_seen;
      int           errors_seen;

      function new();
         cfg = CFG_RESET;
      endfunction

      function int pending();
         return due_draws.size();
      endfunction

      function void track_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
         case (idx)
            REG_MODE:   cfg.mode = mode_type'(data[1:0]);
            REG_PAGE_W: cfg.page_w = data;
            REG_PAGE_H: cfg.page_h = data;
            REG_SCR_W:  cfg.scr_w = data;
            REG_SCR_H:  cfg.scr_h = data;
            default: ;
         endcase
      endfunction

      function int unsigned plane_bytes();
         int unsigned w, h;
         w = cfg.page_w;
         h = cfg.page_h;
         if (w == 0 || h == 0 || w > MAX_DIM || h > MAX_DIM) return 0;
         if (cfg.mode == MODE_MONO) return ((w + 7) / 8) * h;
         return ((h + 7) / 8) * w;
      endfunction

      function void add_pixel(int unsigned x, int unsigned y, logic ink);
         draw_cmd_type cmd;
         cmd.x    = x[PIX_W-1:0];
         cmd.y    = y[PIX_W-1:0];
         cmd.ink  = ink;
         cmd.err  = 1'b0;
         cmd.last = 1'b0;
         due_draws.push_back(cmd);
      endfunction

      function void note_byte(logic [OFF_W-1:0] off, logic [BYTE_W-1:0] hi,
                              logic [BYTE_W-1:0] lo);
         int unsigned  w, h, unit, x, y, base, first;
         logic [1:0]   val;
         draw_cmd_type cmd;
         bytes_seen++;
         first = due_draws.size();
         w = cfg.page_w;
         h = cfg.page_h;
         unit = (cfg.mode == MODE_MONO) ? (w + 7) / 8 : (h + 7) / 8;
         if (off >= plane_bytes()) begin
            cmd = '0;
            cmd.err  = 1'b1;
            cmd.last = 1'b1;
            due_draws.push_back(cmd);
            return;
         end
         base = (off % unit) * 8;
         if (cfg.mode == MODE_MONO) begin
            y = off / unit;
            if (y < h && y < cfg.scr_h && hi != BYTE_BLANK) begin
               for (int b = 0; b < NPIX; b++) begin
                  x = base + b;
                  if (x >= w || x >= cfg.scr_w) break;
                  if (!hi[7-b]) add_pixel(x, y, 1'b1);
               end
            end
         end else begin
            x = w - 1 - off / unit;
            if (x < cfg.scr_w) begin
               for (int b = 0; b < NPIX; b++) begin
                  y = base + b;
                  if (y >= h) break;
                  if (y >= cfg.scr_h) continue;
                  val = {hi[7-b], lo[7-b]};
                  case (cfg.mode)
                     MODE_GRAY_BASE: if (val != 2'd0) add_pixel(x, y, 1'b1);
                     MODE_GRAY_LSB:  if (val == 2'd1) add_pixel(x, y, 1'b0);
                     default:
                        if (val == 2'd1 || val == 2'd2) add_pixel(x, y, 1'b0);
                  endcase
               end
            end
         end
         if (due_draws.size() > first) due_draws[$].last = 1'b1;
      endfunction

      task report(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      task check_result(logic [PIX_W-1:0] x, logic [PIX_W-1:0] y, logic ink,
                        logic err, logic last);
         draw_cmd_type want;
         if (err) errors_seen++;
         else pixels_seen++;
         if (due_draws.size() == 0) begin
            report($sformatf("unexpected result x=%0d y=%0d ink=%0b err=%0b",
                             x, y, ink, err));
            return;
         end
         want = due_draws.pop_front();
         if (x !== want.x)
            report($sformatf("pixel_x %0d, want %0d", x, want.x));
         if (y !== want.y)
            report($sformatf("pixel_y %0d, want %0d", y, want.y));
         if (ink !== want.ink)
            report($sformatf("ink_black %0b, want %0b at (%0d,%0d)",
                             ink, want.ink, want.x, want.y));
         if (err !== want.err)
            report($sformatf("overflow_error %0b, want %0b", err, want.err));
         if (last !== want.last)
            report($sformatf("last_of_byte %0b, want %0b at (%0d,%0d)",
                             last, want.last, want.x, want.y));
      endtask
   endclass

   logic clock;
   logic reset;

   pbpe_req_if req_bus ();
   pbpe_rsp_if rsp_bus ();
   pbpe_csr_if csr_bus ();

   draw_predictor draws = new();

   bit gaps_on    = 1'b1;
   bit hold_armed = 1'b0;
   bit hold_done  = 1'b0;
   int settings_used = 0;
   int idle_cycles   = 0;

   page_bitmap_pixel_expander #(.MAX_DIM(MAX_DIM)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_bus.valid && csr_bus.ready)
            draws.track_reg(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready)
            draws.note_byte(req_bus.byte_offset, req_bus.byte_hi, req_bus.byte_lo);
         if (rsp_bus.valid && rsp_bus.ready)
            draws.check_result(rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.ink_black,
                               rsp_bus.overflow_error, rsp_bus.last_of_byte);
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_armed && !hold_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_bus.ready <= !gaps_on || ($urandom_range(99) >= 30);
         end
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready) || reset)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_byte(logic [OFF_W-1:0] off, logic [BYTE_W-1:0] hi,
                            logic [BYTE_W-1:0] lo);
      while (gaps_on && $urandom_range(99) < 30) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.byte_offset <= off;
      req_bus.byte_hi     <= hi;
      req_bus.byte_lo     <= lo;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic csr_write(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
   endtask

   // wait until every draw is back and bytes with no draw have drained
   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (draws.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_setup(mode_type m, logic [DIM_W-1:0] pw, logic [DIM_W-1:0] ph,
                              logic [DIM_W-1:0] sw, logic [DIM_W-1:0] sh);
      settle();
      csr_write(REG_MODE, DIM_W'(m));
      csr_write(REG_PAGE_W, pw);
      csr_write(REG_PAGE_H, ph);
      csr_write(REG_SCR_W, sw);
      csr_write(REG_SCR_H, sh);
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_setup();
      int unsigned pw, ph, sw, sh;
      pw = ($urandom_range(11) == 0) ? $urandom_range(4095) : $urandom_range(48, 1);
      ph = ($urandom_range(11) == 0) ? $urandom_range(4095) : $urandom_range(48, 1);
      sw = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(pw + 6, 1);
      sh = ($urandom_range(7) == 0) ? $urandom_range(4095) : $urandom_range(ph + 6, 1);
      apply_setup(mode_type'($urandom_range(3)), DIM_W'(pw), DIM_W'(ph),
                  DIM_W'(sw), DIM_W'(sh));
   endtask

   function automatic logic [BYTE_W-1:0] rand_byte();
      case ($urandom_range(9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return BYTE_W'($urandom());
      endcase
   endfunction

   function automatic logic [OFF_W-1:0] rand_offset();
      int unsigned plane, pick;
      plane = draws.plane_bytes();
      pick  = $urandom_range(99);
      if (plane != 0 && pick < 85) return OFF_W'($urandom_range(plane - 1, 0));
      if (pick < 93) return OFF_W'(plane + $urandom_range(3));
      return OFF_W'($urandom());
   endfunction

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.byte_offset <= '0;
      req_bus.byte_hi     <= '0;
      req_bus.byte_lo     <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= REG_MODE;
      csr_bus.data        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: one-bit mode, 480x800 page and screen
      send_byte(19'd0, 8'h00, 8'h00);
      send_byte(19'd0, 8'hFF, 8'h00);
      send_byte(19'd59, 8'h5A, 8'hFF);
      send_byte(19'd47999, 8'h00, 8'h00);
      send_byte(19'd48000, 8'h00, 8'h00);
      send_byte(19'h7FFFF, 8'h81, 8'h7E);

      // odd page size, screen smaller than page
      apply_setup(MODE_MONO, 12'd13, 12'd13, 12'd10, 12'd11);
      send_byte(19'd1, 8'h00, 8'h00);
      send_byte(19'd22, 8'h3C, 8'h00);
      send_byte(19'd26, 8'h00, 8'h00);

      apply_setup(MODE_GRAY_BASE, 12'd13, 12'd13, 12'd10, 12'd11);
      send_byte(19'd0, 8'h00, 8'h00);
      send_byte(19'd6, 8'hCC, 8'hAA);
      send_byte(19'd7, 8'hFF, 8'h00);

      apply_setup(MODE_GRAY_LSB, 12'd13, 12'd13, 12'd10, 12'd11);
      send_byte(19'd6, 8'hCC, 8'hAA);
      send_byte(19'd25, 8'h00, 8'hFF);

      apply_setup(MODE_GRAY_MSB, 12'd13, 12'd13, 12'd10, 12'd11);
      send_byte(19'd6, 8'hCC, 8'hAA);
      send_byte(19'd24, 8'h55, 8'hAA);

      // invalid page sizes turn every byte into an offset error
      apply_setup(MODE_GRAY_MSB, 12'd0, 12'd13, 12'd10, 12'd11);
      send_byte(19'd0, 8'h00, 8'h00);
      apply_setup(MODE_MONO, 12'd2049, 12'd8, 12'd4095, 12'd4095);
      send_byte(19'd0, 8'h00, 8'h00);
      apply_setup(MODE_GRAY_BASE, 12'd8, 12'd4095, 12'd4095, 12'd4095);
      send_byte(19'd0, 8'hFF, 8'hFF);

      // zero-size screen clips everything
      apply_setup(MODE_MONO, 12'd16, 12'd4, 12'd0, 12'd4);
      send_byte(19'd0, 8'h00, 8'h00);
      apply_setup(MODE_GRAY_LSB, 12'd4, 12'd16, 12'd4, 12'd0);
      send_byte(19'd0, 8'h00, 8'hFF);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: apply_setup(MODE_GRAY_BASE, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
            1: apply_setup(MODE_MONO, 12'd2048, 12'd2048, 12'd2048, 12'd2048);
            2: apply_setup(MODE_GRAY_MSB, 12'd1, 12'd1, 12'd1, 12'd1);
            default: random_setup();
         endcase
         gaps_on = (p != 4);
         if (p == 1) hold_armed = 1'b1;
         repeat (PHASE_BYTES) send_byte(rand_offset(), rand_byte(), rand_byte());
      end
      gaps_on = 1'b1;
      settle();

      $display("run covered %0d bytes giving %0d pixel draws and %0d offset errors",
               draws.bytes_seen, draws.pixels_seen, draws.errors_seen);
      $display("over %0d register settings in all four modes, with %0d mismatches",
               settings_used + 1, draws.mismatches);
      if (draws.mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/pbpe_pkg.sv
sv/pbpe_req_if.sv
sv/pbpe_rsp_if.sv
sv/pbpe_csr_if.sv
sv/pbpe_csr.sv
sv/pbpe_div_stage.sv
sv/pbpe_decode.sv
sv/pbpe_emit.sv
sv/page_bitmap_pixel_expander.sv
tb/page_bitmap_pixel_expander_tb.sv
